// ----- hw/rtl/bspm_pkg.sv -----
// Shared types, codes and constants for the buffer slot pool manager.
package bspm_pkg;

  localparam int SLOT_COUNT_DEF = 8;

  localparam logic [2:0] KIND_ACQUIRE  = 3'd0;
  localparam logic [2:0] KIND_TAKE_OLD = 3'd1;
  localparam logic [2:0] KIND_TAKE_NEW = 3'd2;
  localparam logic [2:0] KIND_RELEASE  = 3'd3;
  localparam logic [2:0] KIND_COMMIT   = 3'd4;
  localparam logic [2:0] KIND_PURGE    = 3'd5;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_NONE  = 2'd1;
  localparam logic [1:0] STATUS_BUSY  = 2'd2;
  localparam logic [1:0] STATUS_RANGE = 2'd3;

  localparam logic [1:0] SLOT_EMPTY  = 2'd0;
  localparam logic [1:0] SLOT_FILLED = 2'd1;
  localparam logic [1:0] SLOT_LOCKED = 2'd2;

  localparam logic [31:0] STAMP_NEVER = 32'hffff_ffff;

  localparam logic REG_SLOTS_IN_USE = 1'b0;
  localparam logic [3:0] SLOTS_IN_USE_RESET = 4'd8;

  typedef struct packed {
    logic [2:0]  kind;
    logic [2:0]  slot;
    logic [31:0] stamp;
  } cmd_t;

  typedef struct packed {
    logic [1:0] status;
    logic [2:0] chosen_slot;
    logic       evicted;
  } res_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_RECENT,
    ST_SCAN,
    ST_DRAIN,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic load;
    logic rd_recent;
    logic rd_scan;
    logic recent_chk;
    logic finish;
  } dp_ctl_t;

  typedef struct packed {
    logic [2:0] kind;
    logic       recent_hit;
    logic       scan_last;
  } dp_sts_t;

endpackage

// ----- hw/rtl/bspm_cfg.sv -----
// APB register holding slots_in_use, and the clamped live slot count derived from it.
module bspm_cfg import bspm_pkg::*; #(
  parameter int SLOT_COUNT = SLOT_COUNT_DEF,
  localparam int CNT_W = $clog2(SLOT_COUNT + 1)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [2:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  output logic [CNT_W-1:0] live_n
);

  localparam int CW = (CNT_W > 4) ? CNT_W : 4;

  logic [3:0]    slots_in_use;
  logic          reg_sel;
  logic [CW-1:0] cfg_ext;

  assign pready  = 1'b1;
  assign reg_sel = (paddr[2] == REG_SLOTS_IN_USE);

  always_ff @(posedge clk) begin
    if (rst) begin
      slots_in_use <= SLOTS_IN_USE_RESET;
    end else if (psel && penable && pwrite && reg_sel) begin
      slots_in_use <= pwdata[3:0];
    end
  end

  assign prdata = reg_sel ? {28'd0, slots_in_use} : 32'd0;

  // clamp to 1..SLOT_COUNT
  always_comb begin
    cfg_ext = CW'(slots_in_use);
    if (cfg_ext == '0) begin
      live_n = CNT_W'(1);
    end else if (cfg_ext > CW'(SLOT_COUNT)) begin
      live_n = CNT_W'(SLOT_COUNT);
    end else begin
      live_n = CNT_W'(cfg_ext);
    end
  end

endmodule

// ----- hw/rtl/bspm_ctrl.sv -----
// Request sequencer: dispatch, remembered-slot check, slot scan, drain, finish.
module bspm_ctrl import bspm_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  output logic    busy,
  output dp_ctl_t ctl,
  input  dp_sts_t sts
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    ctl        = '0;
    busy       = (state != ST_IDLE);
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          ctl.load   = 1'b1;
          state_next = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        unique case (sts.kind) inside
          KIND_ACQUIRE: begin
            ctl.rd_recent = 1'b1;
            state_next    = ST_RECENT;
          end
          KIND_TAKE_OLD, KIND_TAKE_NEW: begin
            state_next = ST_SCAN;
          end
          default: begin
            state_next = ST_FINISH;
          end
        endcase
      end
      ST_RECENT: begin
        ctl.recent_chk = 1'b1;
        state_next     = sts.recent_hit ? ST_FINISH : ST_SCAN;
      end
      ST_SCAN: begin
        ctl.rd_scan = 1'b1;
        if (sts.scan_last) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_next = ST_FINISH;
      end
      ST_FINISH: begin
        ctl.finish = 1'b1;
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ----- hw/rtl/bspm_dp.sv -----
// Slot state and timestamp stores, scan compare unit and result register.
module bspm_dp import bspm_pkg::*; #(
  parameter int SLOT_COUNT = SLOT_COUNT_DEF,
  localparam int CNT_W = $clog2(SLOT_COUNT + 1)
) (
  input  logic             clk,
  input  logic             rst,
  input  cmd_t             cmd_in,
  input  logic [CNT_W-1:0] live_n,
  input  dp_ctl_t          ctl,
  output dp_sts_t          sts,
  output logic             done,
  output res_t             res
);

  localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int SW    = (CNT_W > 3) ? CNT_W : 3;

  logic [1:0]  stat_mem [SLOT_COUNT];
  logic [31:0] time_mem [SLOT_COUNT];
  logic [SLOT_COUNT-1:0] valid;

  cmd_t             cmd_q;
  logic             hit_q;
  logic             recent_valid;
  logic [2:0]       recent_slot;
  logic [IDX_W-1:0] scan_idx, cmp_idx, rd_addr;
  logic             cmp_valid;

  logic [1:0]  stat_raw;
  logic        valid_rd;
  logic [31:0] time_rd;
  logic [1:0]  stat_rd;

  logic             empty_found, old_found, new_found;
  logic [IDX_W-1:0] empty_idx, old_idx, new_idx;
  logic [31:0]      old_best, new_best;
  logic [1:0]       slot0_stat;

  // finish decisions
  res_t             res_next;
  logic [IDX_W-1:0] wr_addr, slot_idx, victim;
  logic             slot_ok;
  logic             stat_we, time_we, set_one, clr_one, purge, remember;
  logic [1:0]       wr_stat;
  logic [SLOT_COUNT-1:0] purge_mask;

  assign rd_addr  = ctl.rd_recent ? IDX_W'(recent_slot) : scan_idx;
  assign stat_rd  = valid_rd ? stat_raw : SLOT_EMPTY;
  assign slot_idx = IDX_W'(cmd_q.slot);
  assign slot_ok  = SW'(cmd_q.slot) < SW'(live_n);
  assign victim   = old_found ? old_idx : '0;

  assign sts.kind       = cmd_q.kind;
  assign sts.recent_hit = recent_valid && (SW'(recent_slot) < SW'(live_n)) &&
                          (stat_rd == SLOT_EMPTY);
  assign sts.scan_last  = (CNT_W'(scan_idx) + CNT_W'(1)) == live_n;

  // registered read port
  always_ff @(posedge clk) begin
    stat_raw <= stat_mem[rd_addr];
    time_rd  <= time_mem[rd_addr];
    valid_rd <= valid[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (ctl.finish && stat_we) begin
      stat_mem[wr_addr] <= wr_stat;
    end
    if (ctl.finish && time_we) begin
      time_mem[wr_addr] <= cmd_q.stamp;
    end
  end

  always_comb begin
    for (int i = 0; i < SLOT_COUNT; i++) begin
      purge_mask[i] = CNT_W'(i) < live_n;
    end
  end

  // an entry without its valid bit reads as empty
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (ctl.finish) begin
      if (purge) begin
        valid <= valid & ~purge_mask;
      end else if (set_one) begin
        valid[wr_addr] <= 1'b1;
      end else if (clr_one) begin
        valid[wr_addr] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      recent_valid <= 1'b0;
      recent_slot  <= '0;
      cmp_valid    <= 1'b0;
      done         <= 1'b0;
    end else begin
      cmp_valid <= ctl.rd_scan;
      done      <= ctl.finish;
      if (ctl.recent_chk) begin
        recent_valid <= 1'b0;
      end else if (ctl.finish && remember) begin
        recent_valid <= 1'b1;
        recent_slot  <= cmd_q.slot;
      end
    end
  end

  always_ff @(posedge clk) begin
    cmp_idx <= scan_idx;
    if (ctl.finish) begin
      res <= res_next;
    end
    if (ctl.load) begin
      cmd_q       <= cmd_in;
      hit_q       <= 1'b0;
      scan_idx    <= '0;
      empty_found <= 1'b0;
      old_found   <= 1'b0;
      new_found   <= 1'b0;
      old_best    <= STAMP_NEVER;
      new_best    <= '0;
      slot0_stat  <= SLOT_EMPTY;
    end else begin
      if (ctl.recent_chk) begin
        hit_q <= sts.recent_hit;
      end
      if (ctl.rd_scan) begin
        scan_idx <= scan_idx + 1'b1;
      end
      if (cmp_valid) begin
        if (cmp_idx == '0) begin
          slot0_stat <= stat_rd;
        end
        if (stat_rd == SLOT_EMPTY && !empty_found) begin
          empty_found <= 1'b1;
          empty_idx   <= cmp_idx;
        end
        if (stat_rd == SLOT_FILLED && time_rd < old_best) begin
          old_found <= 1'b1;
          old_idx   <= cmp_idx;
          old_best  <= time_rd;
        end
        if (stat_rd == SLOT_FILLED && time_rd > new_best) begin
          new_found <= 1'b1;
          new_idx   <= cmp_idx;
          new_best  <= time_rd;
        end
      end
    end
  end

  always_comb begin
    res_next = '{status: STATUS_OK, chosen_slot: 3'd0, evicted: 1'b0};
    wr_addr  = slot_idx;
    wr_stat  = SLOT_EMPTY;
    stat_we  = 1'b0;
    time_we  = 1'b0;
    set_one  = 1'b0;
    clr_one  = 1'b0;
    purge    = 1'b0;
    remember = 1'b0;
    case (cmd_q.kind)
      KIND_ACQUIRE: begin
        if (hit_q) begin
          res_next.chosen_slot = recent_slot;
        end else if (empty_found) begin
          res_next.chosen_slot = 3'(empty_idx);
        end else begin
          wr_addr              = victim;
          res_next.chosen_slot = 3'(victim);
          if (!old_found && slot0_stat == SLOT_LOCKED) begin
            res_next.status = STATUS_BUSY;
          end else begin
            clr_one          = 1'b1;
            res_next.evicted = 1'b1;
          end
        end
      end
      KIND_TAKE_OLD: begin
        if (old_found) begin
          wr_addr              = old_idx;
          wr_stat              = SLOT_LOCKED;
          stat_we              = 1'b1;
          set_one              = 1'b1;
          res_next.chosen_slot = 3'(old_idx);
        end else begin
          res_next.status = STATUS_NONE;
        end
      end
      KIND_TAKE_NEW: begin
        if (new_found) begin
          wr_addr              = new_idx;
          wr_stat              = SLOT_LOCKED;
          stat_we              = 1'b1;
          set_one              = 1'b1;
          res_next.chosen_slot = 3'(new_idx);
        end else begin
          res_next.status = STATUS_NONE;
        end
      end
      KIND_RELEASE: begin
        res_next.chosen_slot = cmd_q.slot;
        if (slot_ok) begin
          clr_one  = 1'b1;
          remember = 1'b1;
        end else begin
          res_next.status = STATUS_RANGE;
        end
      end
      KIND_COMMIT: begin
        res_next.chosen_slot = cmd_q.slot;
        if (slot_ok) begin
          wr_stat = SLOT_FILLED;
          stat_we = 1'b1;
          time_we = 1'b1;
          set_one = 1'b1;
        end else begin
          res_next.status = STATUS_RANGE;
        end
      end
      KIND_PURGE: begin
        purge = 1'b1;
      end
      default: begin
      end
    endcase
  end

endmodule

// ----- hw/rtl/buffer_slot_pool_manager.sv -----
// Steps: DISPATCH, then FINISH; the result strobe comes in the cycle after FINISH.
// Release/commit/purge go from DISPATCH to FINISH, an acquire adds the RECENT check of the
// remembered slot, and take-oldest/newest or a missed acquire add SCAN over n (the live
// slot count) and DRAIN. A new request is taken only while idle; the scan reads one slot
// a cycle through the single registered read port of the slot state/timestamp store.
// Reset (rst, synchronous): all slots empty, no remembered slot, slots_in_use = 8.
module buffer_slot_pool_manager import bspm_pkg::*; #(
  parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // request beat: taken when start is high and busy is low
  input  logic        start,
  output logic        busy,
  input  cmd_t        cmd,
  // result beat: valid for the single cycle done is high
  output logic        done,
  output res_t        res,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int CNT_W = $clog2(SLOT_COUNT + 1);

  logic [CNT_W-1:0] live_n;
  dp_ctl_t          ctl;
  dp_sts_t          sts;

  // Register block: holds slots_in_use and hands down the clamped count.
  bspm_cfg #(.SLOT_COUNT(SLOT_COUNT)) u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .live_n  (live_n)
  );

  // Sequencer: walks each request through dispatch, the remembered-slot check,
  // the slot scan and the finishing update.
  bspm_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .ctl   (ctl),
    .sts   (sts)
  );

  // Datapath: slot stores, running oldest/newest/first-empty trackers, and the
  // result register that drives the result beat.
  bspm_dp #(.SLOT_COUNT(SLOT_COUNT)) u_dp (
    .clk    (clk),
    .rst    (rst),
    .cmd_in (cmd),
    .live_n (live_n),
    .ctl    (ctl),
    .sts    (sts),
    .done   (done),
    .res    (res)
  );

  // A result beat only follows a request in flight.
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result beat without a request in flight");

  // The sequencer is back to idle whenever a result is shown.
  a_idle_on_done: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("busy while result beat shown");

  // An accepted request holds the block busy on the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted request did not raise busy");

  // Eviction is only reported together with a good status.
  a_evict_ok: assert property (@(posedge clk) disable iff (rst)
    (done && res.evicted) |-> (res.status == STATUS_OK))
    else $error("eviction flagged on a failed request");

endmodule

// ----- sim/buffer_slot_pool_manager_test.sv -----
// Self-checking testbench for the buffer slot pool manager.
`timescale 1ns / 100ps

module buffer_slot_pool_manager_test import bspm_pkg::*;;

  // Generous bound on the whole run, well beyond the slowest request with the longest gap.
  localparam int CYCLE_LIMIT = 200000;
  localparam int ITEMS_PER_SETTING = 89;
  localparam logic [2:0] ADDR_SLOTS_IN_USE = {REG_SLOTS_IN_USE, 2'b00};
  localparam logic [2:0] KIND_SPARE_LO = 3'd6;
  localparam logic [2:0] KIND_SPARE_HI = 3'd7;

  // Pool predictor plus the queue of results still owed by the block.
  class pool_scoreboard;
    res_t        owed_q[$];
    int          errors;
    logic [1:0]  slot_state[SLOT_COUNT_DEF];
    logic [31:0] slot_stamp[SLOT_COUNT_DEF];
    logic [2:0]  last_freed;
    bit          last_freed_ok;
    logic [3:0]  live_reg;

    function new();
      for (int i = 0; i < SLOT_COUNT_DEF; i++) begin
        slot_state[i] = SLOT_EMPTY;
        slot_stamp[i] = '0;
      end
      last_freed = '0;
      last_freed_ok = 1'b0;
      live_reg = SLOTS_IN_USE_RESET;
      errors = 0;
    endfunction

    function void set_live(logic [3:0] v);
      live_reg = v;
    endfunction

    function int live_slots();
      if (live_reg == 0) return 1;
      if (live_reg > SLOT_COUNT_DEF) return SLOT_COUNT_DEF;
      return live_reg;
    endfunction

    function int pending();
      return owed_q.size();
    endfunction

    // Advance the pool by one request and return the answer it earns.
    function res_t allocate(cmd_t c);
      res_t        r;
      int          n;
      int          pick;
      logic [31:0] best;
      bit          found;
      r = '0;
      n = live_slots();
      case (c.kind)
        KIND_ACQUIRE: begin
          pick = 0;
          best = STAMP_NEVER;
          // The remembered slot gets one chance only.
          if (last_freed_ok) begin
            last_freed_ok = 1'b0;
            if (last_freed < n && slot_state[last_freed] == SLOT_EMPTY) begin
              r.chosen_slot = last_freed;
              return r;
            end
          end
          for (int i = 0; i < n; i++) begin
            if (slot_state[i] == SLOT_EMPTY) begin
              r.chosen_slot = 3'(i);
              return r;
            end
            if (slot_state[i] == SLOT_FILLED && slot_stamp[i] < best) begin
              pick = i;
              best = slot_stamp[i];
            end
          end
          r.chosen_slot = 3'(pick);
          if (slot_state[pick] == SLOT_LOCKED) begin
            r.status = STATUS_BUSY;
          end else begin
            slot_state[pick] = SLOT_EMPTY;
            slot_stamp[pick] = '0;
            r.evicted = 1'b1;
          end
        end
        KIND_TAKE_OLD, KIND_TAKE_NEW: begin
          found = 1'b0;
          pick = 0;
          best = (c.kind == KIND_TAKE_OLD) ? STAMP_NEVER : '0;
          for (int i = 0; i < n; i++) begin
            if (slot_state[i] != SLOT_FILLED) continue;
            if ((c.kind == KIND_TAKE_OLD && slot_stamp[i] < best) ||
                (c.kind == KIND_TAKE_NEW && slot_stamp[i] > best)) begin
              pick = i;
              best = slot_stamp[i];
              found = 1'b1;
            end
          end
          if (!found) begin
            r.status = STATUS_NONE;
          end else begin
            slot_state[pick] = SLOT_LOCKED;
            r.chosen_slot = 3'(pick);
          end
        end
        KIND_RELEASE, KIND_COMMIT: begin
          r.chosen_slot = c.slot;
          if (c.slot >= n) begin
            r.status = STATUS_RANGE;
          end else if (c.kind == KIND_RELEASE) begin
            slot_state[c.slot] = SLOT_EMPTY;
            slot_stamp[c.slot] = '0;
            last_freed = c.slot;
            last_freed_ok = 1'b1;
          end else begin
            slot_state[c.slot] = SLOT_FILLED;
            slot_stamp[c.slot] = c.stamp;
          end
        end
        KIND_PURGE: begin
          for (int i = 0; i < n; i++) begin
            slot_state[i] = SLOT_EMPTY;
            slot_stamp[i] = '0;
          end
        end
        default: ;
      endcase
      return r;
    endfunction

    function void note_request(cmd_t c);
      owed_q.push_back(allocate(c));
    endfunction

    function void check_result(res_t got);
      res_t want;
      if (owed_q.size() == 0) begin
        $error("result beat with nothing owed: status %0d slot %0d evicted %0d",
               got.status, got.chosen_slot, got.evicted);
        errors++;
        return;
      end
      want = owed_q.pop_front();
      if (got.status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, got.status);
        errors++;
      end
      if (got.chosen_slot !== want.chosen_slot) begin
        $error("chosen_slot: expected %0d, got %0d", want.chosen_slot, got.chosen_slot);
        errors++;
      end
      if (got.evicted !== want.evicted) begin
        $error("evicted: expected %0d, got %0d", want.evicted, got.evicted);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst;
  logic        start;
  logic        busy;
  cmd_t        cmd;
  logic        done;
  res_t        res;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  pool_scoreboard pool_sb = new();
  int cycles = 0;
  int calm_left = 0;

  buffer_slot_pool_manager i_dut (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .cmd     (cmd),
    .done    (done),
    .res     (res),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Results cannot be held off: check every strobed beat as it passes.
  always @(posedge clk) begin
    if (!rst && done) pool_sb.check_result(res);
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Issue one request beat. Called at a rising edge; returns at the edge that takes it.
  task automatic send_request(cmd_t c);
    int gap;
    // Mix random gaps with back-to-back stretches.
    if (calm_left > 0) begin
      calm_left--;
      gap = 0;
    end else begin
      gap = $urandom_range(0, 8);
      if ($urandom_range(0, 19) == 0) calm_left = $urandom_range(5, 20);
    end
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    cmd <= c;
    // busy read here is the value from before this edge.
    do @(posedge clk); while (busy);
    pool_sb.note_request(c);
  endtask

  task automatic send_kind(logic [2:0] k, logic [2:0] s, logic [31:0] t);
    cmd_t c;
    c.kind = k;
    c.slot = s;
    c.stamp = t;
    send_request(c);
  endtask

  // Write slots_in_use once the pool has drained, then read it back.
  task automatic set_slots_in_use(logic [3:0] v);
    start <= 1'b0;
    while (pool_sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_SLOTS_IN_USE;
    pwdata <= {28'($urandom), v};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata[3:0] !== v) begin
      $error("slots_in_use readback: expected %0d, got %0d", v, prdata[3:0]);
      pool_sb.errors++;
    end
    psel <= 1'b0;
    penable <= 1'b0;
    pool_sb.set_live(v);
    @(posedge clk);
  endtask

  // Random request, biased so the pool fills, ages and gets contested.
  function automatic cmd_t random_request(int n);
    cmd_t c;
    int   pct;
    pct = $urandom_range(0, 99);
    if (pct < 30)      c.kind = KIND_COMMIT;
    else if (pct < 50) c.kind = KIND_ACQUIRE;
    else if (pct < 62) c.kind = KIND_TAKE_OLD;
    else if (pct < 74) c.kind = KIND_TAKE_NEW;
    else if (pct < 89) c.kind = KIND_RELEASE;
    else if (pct < 94) c.kind = KIND_PURGE;
    else if (pct < 97) c.kind = KIND_SPARE_LO;
    else               c.kind = KIND_SPARE_HI;
    // Mostly live slots; sometimes any index to hit the range check.
    if ($urandom_range(0, 99) < 85) c.slot = 3'($urandom_range(0, n - 1));
    else                            c.slot = 3'($urandom_range(0, 7));
    // Small stamps force ties; the all-ones stamp is never oldest and zero is never newest.
    case ($urandom_range(0, 5))
      0:       c.stamp = '0;
      1:       c.stamp = STAMP_NEVER;
      2, 3:    c.stamp = $urandom_range(0, 7);
      default: c.stamp = $urandom;
    endcase
    return c;
  endfunction

  initial begin
    logic [3:0] settings[$];
    rst = 1'b1;
    start = 1'b0;
    cmd = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part at the reset width of eight slots.
    send_kind(KIND_ACQUIRE, 3'd0, '0);          // empty pool hands out slot 0
    send_kind(KIND_TAKE_OLD, 3'd0, '0);         // nothing filled yet
    send_kind(KIND_TAKE_NEW, 3'd0, '0);
    send_kind(KIND_COMMIT, 3'd7, STAMP_NEVER);
    send_kind(KIND_COMMIT, 3'd0, '0);
    send_kind(KIND_TAKE_NEW, 3'd0, '0);         // all-ones stamp is newest
    send_kind(KIND_TAKE_OLD, 3'd0, '0);         // zero stamp is oldest
    send_kind(KIND_TAKE_OLD, 3'd0, '0);         // both locked: none found
    send_kind(KIND_RELEASE, 3'd3, '0);
    send_kind(KIND_COMMIT, 3'd3, 32'd5);        // remembered slot no longer empty
    send_kind(KIND_ACQUIRE, 3'd0, '0);
    send_kind(KIND_PURGE, 3'd0, '0);
    for (int i = 0; i < SLOT_COUNT_DEF; i++) send_kind(KIND_COMMIT, 3'(i), STAMP_NEVER);
    send_kind(KIND_TAKE_NEW, 3'd0, '0);         // ties: first slot wins, lock slot 0
    send_kind(KIND_ACQUIRE, 3'd0, '0);          // victim falls back to locked slot 0
    send_kind(KIND_RELEASE, 3'd0, '0);
    send_kind(KIND_ACQUIRE, 3'd0, '0);          // remembered slot reused
    send_kind(KIND_COMMIT, 3'd0, 32'd1);
    send_kind(KIND_ACQUIRE, 3'd0, '0);          // full pool: evict slot 0
    send_kind(KIND_SPARE_LO, 3'd7, STAMP_NEVER);
    send_kind(KIND_SPARE_HI, 3'd7, STAMP_NEVER);

    // Random part across widths, extremes and clamped values included.
    settings = '{4'd1, 4'd0, 4'd15, 4'd8, 4'd3, 4'd5, 4'd2, 4'd7, 4'd4, 4'd6, 4'd1};
    settings.push_back(4'($urandom_range(0, 15)));
    foreach (settings[k]) begin
      set_slots_in_use(settings[k]);
      for (int j = 0; j < ITEMS_PER_SETTING; j++)
        send_request(random_request(pool_sb.live_slots()));
    end

    start <= 1'b0;
    while (pool_sb.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (pool_sb.errors == 0 && pool_sb.pending() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
